// ----- rtl/pswp_pkg.sv -----
// Shared types and constants for the PLL synthesizer word programmer.
package pswp_pkg;

  // Field widths fixed by the interface
  localparam int FREQ_W  = 22;
  localparam int PFD_W   = 16;
  localparam int REF_W   = 14;
  localparam int CUR_W   = 3;
  localparam int MUX_W   = 3;
  localparam int BL_W    = 2;
  localparam int WORD_W  = 24;
  localparam int IDX_W   = 3;
  localparam int B_W     = 13;
  localparam int A_W     = 6;

  // Request queue depth between the front and back parts
  localparam int QDEPTH  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PFD      = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURRENT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MUX      = 3'd3;
  localparam logic [IDX_W-1:0] REG_POLARITY = 3'd4;
  localparam logic [IDX_W-1:0] REG_BACKLASH = 3'd5;

  // Latch control bits
  localparam logic [1:0] CTL_REF  = 2'b00;
  localparam logic [1:0] CTL_AB   = 2'b01;
  localparam logic [1:0] CTL_FUNC = 2'b10;

  // Configuration bundle
  typedef struct packed {
    logic [PFD_W-1:0] pfd_khz;
    logic [REF_W-1:0] ref_count;
    logic [CUR_W-1:0] pump_current;
    logic [MUX_W-1:0] mux_select;
    logic             pump_polarity;
    logic [BL_W-1:0]  backlash_code;
  } cfg_t;

  // Queued request: frequency plus zero-divisor class
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              zero_div;
  } req_t;

  // Divider control and response
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [PFD_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/pswp_front.sv -----
// Front part: accepts frequency items, classifies them and queues them.
module pswp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [pswp_pkg::FREQ_W-1:0] freq_khz,
  input  logic                       pfd_zero,
  output logic                       q_valid,
  output pswp_pkg::req_t             q_data,
  input  logic                       q_pop
);
  import pswp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  req_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign full    = (count == CNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];
  assign do_push = push && !full;

  // Queue storage, written on accept
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= '{freq: freq_khz, zero_div: pfd_zero};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pswp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pswp_div (
  input  logic               clk,
  input  logic               rst,
  input  pswp_pkg::div_req_t req,
  output pswp_pkg::div_rsp_t rsp
);
  import pswp_pkg::*;

  localparam int CNT_W = $clog2(FREQ_W + 1);

  logic [FREQ_W-1:0] quo;
  logic [PFD_W-1:0]  rem;
  logic [PFD_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [PFD_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, quo[FREQ_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FREQ_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[FREQ_W-2:0], fits};
      rem <= fits ? PFD_W'(trial - {1'b0, divisor}) : trial[PFD_W-1:0];
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quo};

endmodule

// ----- rtl/pswp_back.sv -----
// Back part: computes N, A and B and emits the four latch words.
module pswp_back #(
  parameter int PRESCALE_P = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pswp_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  pswp_pkg::req_t              q_data,
  output logic                        q_pop,
  output pswp_pkg::div_req_t          div_req,
  input  pswp_pkg::div_rsp_t          div_rsp,
  input  logic                        pop,
  output logic                        out_valid,
  output logic [pswp_pkg::WORD_W-1:0] out_word,
  output logic                        out_last
);
  import pswp_pkg::*;

  localparam logic [1:0] PCODE = (PRESCALE_P >= 32) ? 2'd2 :
                                 (PRESCALE_P >= 16) ? 2'd1 : 2'd0;

  // Rounded-up reciprocal of the prescaler modulus; exact for any 22-bit N
  localparam int SHIFT  = FREQ_W + $clog2(PRESCALE_P);
  localparam int RCP_W  = FREQ_W + 2;
  localparam int PROD_W = FREQ_W + RCP_W;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << SHIFT) + 64'(PRESCALE_P) - 64'd1) / 64'(PRESCALE_P);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);

  typedef enum logic [2:0] {ST_IDLE, ST_DIVN, ST_QUOT, ST_SPLIT, ST_EMIT} state_t;

  state_t            state;
  logic [1:0]        idx;
  logic [FREQ_W-1:0] b_q;
  logic [B_W-1:0]    b_val;
  logic [A_W-1:0]    a_val;
  logic [PROD_W-1:0] prod;
  logic [FREQ_W-1:0] a_full;
  logic              slot_free;
  logic              emit;
  logic [WORD_W-1:0] word_next;

  // Pull the next request when idle and start the division by pfd (zero by one when pfd is zero)
  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    div_req = '0;
    if (q_pop) begin
      div_req.start    = 1'b1;
      div_req.dividend = q_data.zero_div ? '0 : q_data.freq;
      div_req.divisor  = q_data.zero_div ? PFD_W'(1) : cfg.pfd_khz;
    end
  end

  // Split N by the prescaler: B by reciprocal multiply, A as what is left
  // (the divider holds its quotient until the next start)
  assign prod   = PROD_W'(div_rsp.quotient) * PROD_W'(RECIP);
  assign a_full = div_rsp.quotient - b_q * FREQ_W'(PRESCALE_P);

  // Latch word for the current emit slot
  always_comb begin
    case (idx)
      2'd0: word_next = {PCODE, 4'b0, cfg.pump_current, 7'b0, cfg.pump_polarity,
                         cfg.mux_select, 1'b0, 1'b1, CTL_FUNC};
      2'd1: word_next = {6'b0, cfg.backlash_code, cfg.ref_count, CTL_REF};
      2'd2: word_next = {2'b0, 1'b0, b_val, a_val, CTL_AB};
      default: word_next = {PCODE, 4'b0, cfg.pump_current, 7'b0, cfg.pump_polarity,
                            cfg.mux_select, 1'b0, 1'b0, CTL_FUNC};
    endcase
  end

  assign slot_free = !out_valid || pop;
  assign emit      = (state == ST_EMIT) && slot_free;

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (div_rsp.done) begin
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          b_q   <= FREQ_W'(prod >> SHIFT);
          state <= ST_SPLIT;
        end
        ST_SPLIT: begin
          b_val <= b_q[B_W-1:0];
          a_val <= a_full[A_W-1:0];
          idx   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_word <= word_next;
            out_last <= (idx == 2'd3);
            idx      <= idx + 1'b1;
            if (idx == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pll_synth_word_programmer_unit.sv -----
// Top level of the PLL synthesizer word programmer.
// An accepted item passes the queue, the 22-step serial division freq / pfd, the ST_QUOT and
// ST_SPLIT states and the output register to its first latch word; the other three words follow
// back to back while pop keeps up. The back part takes the next item only when idle, after its
// four word slots; meanwhile a two-entry queue takes new items.
// Reset (synchronous, rst high): configuration and control registers take their default values, queue and output empty.
module pll_synth_word_programmer_unit #(
  parameter int PRESCALE_P = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [pswp_pkg::FREQ_W-1:0] freq_khz,
  output logic                        empty,
  input  logic                        pop,
  output logic [pswp_pkg::WORD_W-1:0] latch_word,
  output logic                        last_word,
  input  logic                        wr_en,
  input  logic [pswp_pkg::IDX_W-1:0]  wr_index,
  input  logic [pswp_pkg::PFD_W-1:0]  wr_data
);
  import pswp_pkg::*;

  cfg_t     cfg;
  logic     q_valid;
  req_t     q_data;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pfd_khz       <= PFD_W'(500);
      cfg.ref_count     <= REF_W'(80);
      cfg.pump_current  <= CUR_W'(7);
      cfg.mux_select    <= MUX_W'(2);
      cfg.pump_polarity <= 1'b1;
      cfg.backlash_code <= BL_W'(2);
    end else if (wr_en) begin
      case (wr_index)
        REG_PFD:      cfg.pfd_khz       <= wr_data;
        REG_REF:      cfg.ref_count     <= wr_data[REF_W-1:0];
        REG_CURRENT:  cfg.pump_current  <= wr_data[CUR_W-1:0];
        REG_MUX:      cfg.mux_select    <= wr_data[MUX_W-1:0];
        REG_POLARITY: cfg.pump_polarity <= wr_data[0];
        REG_BACKLASH: cfg.backlash_code <= wr_data[BL_W-1:0];
        default: ;
      endcase
    end
  end

  pswp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .freq_khz (freq_khz),
    .pfd_zero (cfg.pfd_khz == '0),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  pswp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pswp_back #(
    .PRESCALE_P (PRESCALE_P)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (latch_word),
    .out_last  (last_word)
  );

  assign empty = !out_valid;

  // Checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("request taken from empty queue");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> (!full && empty))
    else $error("queue or output not empty after reset");

endmodule
